// ----- rtl/bcs_pkg.sv -----
// Package: types, constants and step tables of the six-step commutation sequencer.
`default_nettype none

package bcs_pkg;

  localparam logic [1:0] NO_PHASE  = 2'd3;
  localparam logic [1:0] PHASE_A   = 2'd0;
  localparam logic [1:0] PHASE_B   = 2'd1;
  localparam logic [1:0] PHASE_C   = 2'd2;
  localparam logic [2:0] STEP_LAST = 3'd5;
  localparam logic [2:0] STEP_ALIGN = 3'd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int TICK_W     = 10;
  localparam int PERIOD_W   = 8;
  localparam int DUTY_W     = 8;

  // Register reset values
  localparam logic [DUTY_W-1:0]   ALIGN_DUTY_RST         = 8'd70;
  localparam logic [DUTY_W-1:0]   RAMP_DUTY_RST          = 8'd50;
  localparam logic [DUTY_W-1:0]   RUN_DUTY_RST           = 8'd150;
  localparam logic [TICK_W-1:0]   ALIGN_FIRST_TICKS_RST  = 10'd160;
  localparam logic [TICK_W-1:0]   ALIGN_SECOND_TICKS_RST = 10'd400;
  localparam logic [PERIOD_W-1:0] RAMP_START_PERIOD_RST  = 8'd50;
  localparam logic [PERIOD_W-1:0] RAMP_END_PERIOD_RST    = 8'd35;

  // Reported mode codes
  localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_CODE_ALIGN = 2'd1;
  localparam logic [1:0] MODE_CODE_RAMP  = 2'd2;
  localparam logic [1:0] MODE_CODE_RUN   = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN_DUTY         = 3'd0,
    CFG_RAMP_DUTY          = 3'd1,
    CFG_RUN_DUTY           = 3'd2,
    CFG_ALIGN_FIRST_TICKS  = 3'd3,
    CFG_ALIGN_SECOND_TICKS = 3'd4,
    CFG_RAMP_START_PERIOD  = 3'd5,
    CFG_RAMP_END_PERIOD    = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_ALIGN = 4'b0010,
    MODE_RAMP  = 4'b0100,
    MODE_RUN   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic opcode;
    logic button_pressed;
  } in_t;

  typedef struct packed {
    logic [1:0] high_phase;
    logic [1:0] low_phase;
    logic [7:0] duty;
    logic [1:0] sense_phase;
    logic       sense_rising;
    logic [2:0] step_now;
    logic [1:0] mode_now;
    logic       edge_armed;
  } out_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   align_duty;
    logic [DUTY_W-1:0]   ramp_duty;
    logic [DUTY_W-1:0]   run_duty;
    logic [TICK_W-1:0]   align_first_ticks;
    logic [TICK_W-1:0]   align_second_ticks;
    logic [PERIOD_W-1:0] ramp_start_period;
    logic [PERIOD_W-1:0] ramp_end_period;
  } cfg_t;

  // Step table: high side, low side, floating phase, expected edge
  function automatic logic [1:0] step_high(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd0, 3'd1: r = PHASE_A;
      3'd2, 3'd3: r = PHASE_B;
      3'd4, 3'd5: r = PHASE_C;
      default:    r = PHASE_A;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_low(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd0, 3'd5: r = PHASE_B;
      3'd1, 3'd2: r = PHASE_C;
      3'd3, 3'd4: r = PHASE_A;
      default:    r = PHASE_B;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] step_sense(input logic [2:0] s);
    logic [1:0] r;
    unique case (s)
      3'd0, 3'd3: r = PHASE_C;
      3'd1, 3'd4: r = PHASE_B;
      3'd2, 3'd5: r = PHASE_A;
      default:    r = PHASE_C;
    endcase
    return r;
  endfunction

  function automatic logic step_rising(input logic [2:0] s);
    return ~s[0];
  endfunction

  function automatic logic [2:0] step_next(input logic [2:0] s);
    return (s < STEP_LAST) ? s + 3'd1 : 3'd0;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bcs_cfg_regs.sv -----
// Configuration register file of the commutation sequencer.
`default_nettype none

module bcs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bcs_pkg::cfg_t                      cfg
);
  import bcs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index; unknown indexes drop the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALIGN_DUTY:         cfg_nxt.align_duty         = cfg_wdata[DUTY_W-1:0];
        CFG_RAMP_DUTY:          cfg_nxt.ramp_duty          = cfg_wdata[DUTY_W-1:0];
        CFG_RUN_DUTY:           cfg_nxt.run_duty           = cfg_wdata[DUTY_W-1:0];
        CFG_ALIGN_FIRST_TICKS:  cfg_nxt.align_first_ticks  = cfg_wdata[TICK_W-1:0];
        CFG_ALIGN_SECOND_TICKS: cfg_nxt.align_second_ticks = cfg_wdata[TICK_W-1:0];
        CFG_RAMP_START_PERIOD:  cfg_nxt.ramp_start_period  = cfg_wdata[PERIOD_W-1:0];
        CFG_RAMP_END_PERIOD:    cfg_nxt.ramp_end_period    = cfg_wdata[PERIOD_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align_duty         <= ALIGN_DUTY_RST;
      cfg_r.ramp_duty          <= RAMP_DUTY_RST;
      cfg_r.run_duty           <= RUN_DUTY_RST;
      cfg_r.align_first_ticks  <= ALIGN_FIRST_TICKS_RST;
      cfg_r.align_second_ticks <= ALIGN_SECOND_TICKS_RST;
      cfg_r.ramp_start_period  <= RAMP_START_PERIOD_RST;
      cfg_r.ramp_end_period    <= RAMP_END_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/bcs_core.sv -----
// Commutation state machine: mode, step, tick counter and ramp period, plus result decode.
`default_nettype none

module bcs_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire bcs_pkg::in_t  in_beat,
  input  wire bcs_pkg::cfg_t cfg,
  output bcs_pkg::out_t      result
);
  import bcs_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [TICK_W-1:0]   pc_r, pc_nxt;
  logic [PERIOD_W-1:0] rp_r, rp_nxt;
  logic                half_r, half_nxt;
  logic                drive_r, drive_nxt;

  logic [TICK_W-1:0]   pc_inc;
  logic [TICK_W-1:0]   rp_ext;
  logic [TICK_W-1:0]   ramp_pc;
  logic [PERIOD_W-1:0] rp_dec;
  logic                rp_zero;
  logic [DUTY_W-1:0]   duty_sel;
  logic [1:0]          mode_code;

  assign pc_inc  = pc_r + TICK_W'(1);
  assign rp_ext  = TICK_W'(rp_r);
  assign ramp_pc = (pc_r < rp_ext) ? pc_inc : pc_r;
  assign rp_zero = (rp_r == '0);
  assign rp_dec  = rp_zero ? rp_r : rp_r - PERIOD_W'(1);

  // Advance the state for one beat
  always_comb begin
    mode_nxt  = mode_r;
    step_nxt  = step_r;
    pc_nxt    = pc_r;
    rp_nxt    = rp_r;
    half_nxt  = half_r;
    drive_nxt = drive_r;
    priority if (mode_r == MODE_RUN && !in_beat.button_pressed) begin
      // button released in run: stop
      mode_nxt  = MODE_IDLE;
      drive_nxt = 1'b0;
    end else if (in_beat.opcode == OP_EDGE) begin
      if (mode_r == MODE_RUN) begin
        step_nxt  = step_next(step_r);
        drive_nxt = 1'b1;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (in_beat.button_pressed) begin
            mode_nxt  = MODE_ALIGN;
            step_nxt  = STEP_ALIGN;
            pc_nxt    = '0;
            half_nxt  = 1'b0;
            drive_nxt = 1'b1;
          end
        end
        MODE_ALIGN: begin
          pc_nxt = pc_inc;
          if (!half_r) begin
            if (pc_inc >= cfg.align_first_ticks) begin
              half_nxt = 1'b1;
              pc_nxt   = '0;
            end
          end else if (pc_inc >= cfg.align_second_ticks) begin
            mode_nxt = MODE_RAMP;
            rp_nxt   = cfg.ramp_start_period;
            pc_nxt   = '0;
          end
        end
        MODE_RAMP: begin
          pc_nxt = ramp_pc;
          if (ramp_pc >= rp_ext) begin
            pc_nxt = '0;
            rp_nxt = rp_dec;
            if (rp_zero || rp_dec < cfg.ramp_end_period) begin
              drive_nxt = 1'b0;
              mode_nxt  = MODE_RUN;
            end else begin
              step_nxt = step_next(step_r);
            end
          end
        end
        MODE_RUN: begin
          mode_nxt = mode_r;
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      step_r  <= '0;
      pc_r    <= '0;
      rp_r    <= '0;
      half_r  <= 1'b0;
      drive_r <= 1'b0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      pc_r    <= pc_nxt;
      rp_r    <= rp_nxt;
      half_r  <= half_nxt;
      drive_r <= drive_nxt;
    end
  end

  // Decode the result from the updated state
  always_comb begin
    duty_sel  = cfg.run_duty;
    mode_code = MODE_CODE_IDLE;
    unique case (mode_nxt)
      MODE_IDLE: begin
        mode_code = MODE_CODE_IDLE;
      end
      MODE_ALIGN: begin
        mode_code = MODE_CODE_ALIGN;
        duty_sel  = half_nxt ? cfg.ramp_duty : cfg.align_duty;
      end
      MODE_RAMP: begin
        mode_code = MODE_CODE_RAMP;
        duty_sel  = cfg.ramp_duty;
      end
      MODE_RUN: begin
        mode_code = MODE_CODE_RUN;
      end
      default: begin
        mode_code = MODE_CODE_IDLE;
      end
    endcase

    if (drive_nxt && mode_nxt != MODE_IDLE) begin
      result.high_phase = step_high(step_nxt);
      result.low_phase  = step_low(step_nxt);
      result.duty       = duty_sel;
    end else begin
      result.high_phase = NO_PHASE;
      result.low_phase  = NO_PHASE;
      result.duty       = '0;
    end
    result.sense_phase  = step_sense(step_nxt);
    result.sense_rising = step_rising(step_nxt);
    result.step_now     = step_nxt;
    result.mode_now     = mode_code;
    result.edge_armed   = (mode_nxt == MODE_RUN);
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("step left its range");

  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mode_r))
    else $error("mode register not one-hot");

  a_idle_undriven: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> !drive_r)
    else $error("drive enabled while idle");

  a_hold_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(step_r) && $stable(pc_r) && $stable(mode_r))
    else $error("state moved without a beat");

endmodule

`default_nettype wire

// ----- rtl/sensorless_bldc_commutation_sequencer_top.sv -----
// Top level of the six-step sensorless commutation sequencer.
//
//   channel | dir | handshake                 | payload
//   in_     | in  | in_valid / in_ready       | in_data   (opcode, button_pressed)
//   out_    | out | out_valid / out_ready     | out_data  (phases, duty, sense, step, mode)
//   cfg_    | in  | cfg_we (no wait)          | cfg_index, cfg_wdata
//
// One beat per cycle sustained while the result is not stalled.
// The beat lands in an input register; the state update and result decode sit
// between it and the result register, and the state commits as the result loads.
// Synchronous active-low reset clears the state to idle with the drive off.
// A stalled result holds in its register while one more input beat is taken.
`default_nettype none

module sensorless_bldc_commutation_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bcs_pkg::in_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bcs_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcs_pkg::*;

  cfg_t cfg;
  in_t  s1_data_r;
  logic s1_valid_r;
  out_t out_data_r;
  logic out_valid_r;
  out_t result;
  logic s1_adv;

  bcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move the input stage forward when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  bcs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .in_beat (s1_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
